// ----- hw/rtl/keypad_scan_password_entry_unit_assert.svh -----
// Assertion macros for the keypad scanner RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef KEYPAD_SCAN_PASSWORD_ENTRY_UNIT_ASSERT_SVH
`define KEYPAD_SCAN_PASSWORD_ENTRY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KPSE_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("keypad scanner assertion failed");
`define KPSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("keypad scanner assertion failed");
`else
`define KPSE_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define KPSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/kpse_pkg.sv -----
// Shared types and constants of the keypad scanner with password entry.
// No dependencies; used by the scan core and the top level.
package kpse_pkg;

	localparam logic [2:0] PH_SETTLE  = 3'd0;
	localparam logic [2:0] PH_PRESS   = 3'd1;
	localparam logic [2:0] PH_WAIT    = 3'd2;
	localparam logic [2:0] PH_RELEASE = 3'd3;

	localparam logic [1:0] REG_SETTLE   = 2'd0;
	localparam logic [1:0] REG_DEBOUNCE = 2'd1;
	localparam logic [1:0] REG_MAXCHARS = 2'd2;

	localparam logic [15:0] SETTLE_RESET   = 16'd100;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20000;
	localparam logic [4:0]  MAXCHARS_RESET = 5'd16;

	localparam logic [6:0] KEY_HASH = 7'h23;
	localparam logic [6:0] KEY_STAR = 7'h2A;

	typedef struct packed {
		logic [3:0] column_levels;
	} sample_t;

	typedef struct packed {
		logic [3:0] row_drive;
		logic       key_event;
		logic [6:0] key_code;
		logic       char_stored;
		logic [3:0] char_index;
		logic       entry_cleared;
		logic       entry_done;
		logic [4:0] entry_length;
	} result_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [15:0] reg_data;
	} cfg_write_t;

	// Effective settings handed from the register file to the scan core.
	typedef struct packed {
		logic [15:0] settle_ticks;
		logic [15:0] debounce_ticks;
		logic [4:0]  max_chars;
	} cfg_regs_t;

	function automatic logic [6:0] key_ascii(input logic [1:0] row, input logic [1:0] col);
		logic [6:0] k;
		case ({row, col})
			4'h0: k = 7'h31;
			4'h1: k = 7'h32;
			4'h2: k = 7'h33;
			4'h3: k = 7'h41;
			4'h4: k = 7'h34;
			4'h5: k = 7'h35;
			4'h6: k = 7'h36;
			4'h7: k = 7'h42;
			4'h8: k = 7'h37;
			4'h9: k = 7'h38;
			4'hA: k = 7'h39;
			4'hB: k = 7'h43;
			4'hC: k = KEY_STAR;
			4'hD: k = 7'h30;
			4'hE: k = KEY_HASH;
			default: k = 7'h44;
		endcase
		return k;
	endfunction

endpackage

// ----- hw/rtl/kpse_stream_if.sv -----
// Valid/ready channel interface carrying one packed payload per transfer.
// Payload types come from kpse_pkg at the point of instantiation.
interface kpse_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/kpse_scan.sv -----
// Scan, debounce and password state machine: one tick per advance pulse.
// Depends on kpse_pkg and the assertion macro header.
`include "keypad_scan_password_entry_unit_assert.svh"
module kpse_scan
	import kpse_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic [3:0] column_levels,
	input  cfg_regs_t cfg,
	output result_t   res
);

	logic [2:0]  phase_q;
	logic [1:0]  row_q;
	logic [1:0]  col_q;
	logic [15:0] tick_q;
	logic [4:0]  count_q;

	logic [2:0]  phase_d;
	logic [1:0]  row_d;
	logic [1:0]  col_d;
	logic [15:0] tick_d;
	logic [4:0]  count_d;

	logic [16:0] tick_next;
	logic [4:0]  maxc;
	logic [4:0]  count_inc;
	logic [6:0]  key;
	logic        settle_done;
	logic        debounce_done;
	logic        col_found;
	logic [1:0]  col_first;

	assign tick_next     = {1'b0, tick_q} + 17'd1;
	assign settle_done   = tick_next >= {1'b0, cfg.settle_ticks};
	assign debounce_done = tick_next >= {1'b0, cfg.debounce_ticks};
	assign key           = key_ascii(row_q, col_q);
	assign count_inc     = count_q + 5'd1;
	assign maxc          = (cfg.max_chars == 5'd0) ? 5'd1 : cfg.max_chars;

	// Lowest pulled-low column wins.
	always_comb begin
		col_found = 1'b1;
		if (!column_levels[0]) begin
			col_first = 2'd0;
		end else if (!column_levels[1]) begin
			col_first = 2'd1;
		end else if (!column_levels[2]) begin
			col_first = 2'd2;
		end else if (!column_levels[3]) begin
			col_first = 2'd3;
		end else begin
			col_first = 2'd0;
			col_found = 1'b0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		col_d   = col_q;
		tick_d  = tick_q;
		count_d = count_q;
		res               = '0;
		res.row_drive     = ~(4'b0001 << row_q);
		case (phase_q)
			PH_PRESS: begin
				if (debounce_done) begin
					tick_d  = '0;
					phase_d = PH_WAIT;
				end else begin
					tick_d = tick_next[15:0];
				end
			end
			PH_WAIT: begin
				if (column_levels[col_q]) begin
					tick_d  = '0;
					phase_d = PH_RELEASE;
				end
			end
			PH_RELEASE: begin
				if (debounce_done) begin
					res.key_event = 1'b1;
					res.key_code  = key;
					if (key == KEY_HASH) begin
						res.entry_done   = 1'b1;
						res.entry_length = count_q;
						count_d          = '0;
					end else if (key == KEY_STAR) begin
						res.entry_cleared = 1'b1;
						count_d           = '0;
					end else begin
						res.char_stored = 1'b1;
						res.char_index  = count_q[3:0];
						// The upper clamp of the limit is already applied by the top level.
						if (count_inc >= maxc) begin
							res.entry_done   = 1'b1;
							res.entry_length = count_inc;
							count_d          = '0;
						end else begin
							count_d = count_inc;
						end
					end
					phase_d = PH_SETTLE;
					row_d   = 2'd0;
					tick_d  = '0;
				end else begin
					tick_d = tick_next[15:0];
				end
			end
			default: begin
				phase_d = PH_SETTLE;
				if (settle_done) begin
					tick_d = '0;
					if (col_found) begin
						col_d   = col_first;
						phase_d = PH_PRESS;
					end else begin
						row_d = row_q + 2'd1;
					end
				end else begin
					tick_d = tick_next[15:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SETTLE;
			row_q   <= '0;
			col_q   <= '0;
			tick_q  <= '0;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			col_q   <= col_d;
			tick_q  <= tick_d;
			count_q <= count_d;
		end
	end

	`KPSE_ASSERT_SAME(a_event_from_release, clk, arst_n, res.key_event, phase_q == PH_RELEASE)
	`KPSE_ASSERT_NEXT(a_restart_after_event, clk, arst_n, advance && res.key_event, phase_q == PH_SETTLE && row_q == 2'd0 && tick_q == 16'd0)
	`KPSE_ASSERT_NEXT(a_row_held_on_key, clk, arst_n, advance && phase_q != PH_SETTLE && !res.key_event, $stable(row_q))
	`KPSE_ASSERT_SAME(a_full_length, clk, arst_n, res.char_stored && res.entry_done, res.entry_length == {1'b0, res.char_index} + 5'd1)

endmodule

// ----- hw/rtl/keypad_scan_password_entry_unit.sv -----
// Keypad scanner with password entry: registers, result register and the scan core.
// Depends on kpse_pkg, kpse_stream_if and kpse_scan.
//
// Usage: every transfer on "sample" is one time tick carrying the column levels
// sampled under the row drive of that tick. For each tick exactly one result
// transfer appears on "result": the row drive in force, and any key event with
// the password bookkeeping it caused (stored character, clear, finished entry).
// Result valid rises in the cycle after the sample transfer. Throughput is
// one tick per cycle: the core updates its state in a single pass and a result
// register sits between it and the receiver, so a new sample is taken in the
// same cycle the previous result is taken. When the receiver stalls, the result
// register holds and sample.ready drops until the result leaves.
// The "cfg" channel is always ready; index 0 is settle_ticks, 1 debounce_ticks,
// 2 max_chars, and any other index is ignored. A write applies from the next tick.
// Reset returns the registers to 100, 20000 and 16, the scan to the settle
// phase on row 0 and the password entry to empty; no result is pending.
module keypad_scan_password_entry_unit
	import kpse_pkg::*;
#(
	parameter int MAX_CHARS_LIMIT = 16
)(
	input logic clk,
	input logic arst_n,
	kpse_stream_if.sink   sample,
	kpse_stream_if.source result,
	kpse_stream_if.sink   cfg
);

	cfg_regs_t  cfg_q;
	cfg_regs_t  cfg_eff;
	cfg_write_t cfg_wr;
	sample_t    smp;
	result_t    core_res;
	result_t    res_q;
	logic       res_valid_q;
	logic       advance;

	assign cfg_wr    = cfg.payload;
	assign smp       = sample.payload;
	assign cfg.ready = 1'b1;

	assign sample.ready   = !res_valid_q || result.ready;
	assign advance        = sample.valid && sample.ready;
	assign result.valid   = res_valid_q;
	assign result.payload = res_q;

	// The upper clamp of the character limit depends on the build parameter.
	always_comb begin
		cfg_eff = cfg_q;
		if ({27'd0, cfg_q.max_chars} > MAX_CHARS_LIMIT) begin
			cfg_eff.max_chars = 5'(MAX_CHARS_LIMIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks   <= SETTLE_RESET;
			cfg_q.debounce_ticks <= DEBOUNCE_RESET;
			cfg_q.max_chars      <= MAXCHARS_RESET;
		end else if (cfg.valid) begin
			case (cfg_wr.reg_index)
				REG_SETTLE:   cfg_q.settle_ticks   <= cfg_wr.reg_data;
				REG_DEBOUNCE: cfg_q.debounce_ticks <= cfg_wr.reg_data;
				REG_MAXCHARS: cfg_q.max_chars      <= cfg_wr.reg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	kpse_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.column_levels (smp.column_levels),
		.cfg           (cfg_eff),
		.res           (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

endmodule
